// ----- sv/sphl_pkg.sv -----
// sphl_pkg: shared constants for the short product high-limb unit
// no dependencies; used by sphl_mac and short_product_high_limbs_unit
`default_nettype none

package sphl_pkg;

  // fixed widths of the external limb ports and the length register
  localparam int PORT_W = 64;
  localparam int CFG_W  = 5;

  // half-limb partial products per limb multiply-add
  localparam int MAC_STEPS = 4;

endpackage

`default_nettype wire

// ----- sv/sphl_ram.sv -----
// sphl_ram: generic single-write, single-read memory with registered read
// no dependencies
`default_nettype none

module sphl_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/sphl_mac.sv -----
// sphl_mac: iterative limb multiply-add a*b + c + d built on one half-limb multiplier
// depends on sphl_pkg
`default_nettype none

module sphl_mac #(
  parameter int LIMB_BITS = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [LIMB_BITS-1:0] a,
  input  wire logic [LIMB_BITS-1:0] b,
  input  wire logic [LIMB_BITS-1:0] c,
  input  wire logic [LIMB_BITS-1:0] d,
  output logic                      done,
  output logic      [LIMB_BITS-1:0] lo,
  output logic      [LIMB_BITS-1:0] hi
);

  localparam int HALF   = (LIMB_BITS + 1) / 2;
  localparam int PROD_W = 2 * HALF;
  localparam int ACC_W  = 2 * LIMB_BITS;

  logic [LIMB_BITS-1:0] a_r;
  logic [LIMB_BITS-1:0] b_r;
  logic [ACC_W-1:0]     acc;
  logic [PROD_W-1:0]    prod;
  logic [1:0]           prod_w;
  logic [2:0]           ph;
  logic                 busy;

  logic [HALF-1:0]      a_sel;
  logic [HALF-1:0]      b_sel;
  logic [PROD_W-1:0]    prod_next;
  logic [ACC_W-1:0]     prod_shifted;

  // half select: bit 0 of the phase picks the half of a, bit 1 the half of b
  always_comb begin
    a_sel     = ph[0] ? HALF'(a_r >> HALF) : HALF'(a_r);
    b_sel     = ph[1] ? HALF'(b_r >> HALF) : HALF'(b_r);
    prod_next = PROD_W'(a_sel) * PROD_W'(b_sel);
  end

  always_comb begin
    unique case (prod_w)
      2'd0:    prod_shifted = ACC_W'(prod);
      2'd1:    prod_shifted = ACC_W'(prod) << HALF;
      2'd2:    prod_shifted = ACC_W'(prod) << (2 * HALF);
      default: prod_shifted = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ph   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_r  <= a;
        b_r  <= b;
        acc  <= ACC_W'(c) + ACC_W'(d);
        ph   <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        // multiply in one phase, add the registered product in the next
        if (ph != 3'(sphl_pkg::MAC_STEPS)) begin
          prod   <= prod_next;
          prod_w <= 2'({1'b0, ph[0]} + {1'b0, ph[1]});
        end
        if (ph != '0) begin
          acc <= acc + prod_shifted;
        end
        if (ph == 3'(sphl_pkg::MAC_STEPS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        ph <= ph + 3'd1;
      end
    end
  end

  assign lo = acc[LIMB_BITS-1:0];
  assign hi = acc[ACC_W-1:LIMB_BITS];

endmodule

`default_nettype wire

// ----- sv/short_product_high_limbs_unit.sv -----
// short_product_high_limbs_unit: truncated high-half product of two n-limb operands
// depends on sphl_pkg, sphl_ram, sphl_mac
// operation: n load transfers, then n*(n+1)/2 limb products, taken one at a time by
//   the shared multiply-add unit, then n+1 result transfers, each with an accumulator
//   read, a capture and the transfer; one product at a time
// reset: synchronous; length register goes to 16, load count and handshakes clear
`default_nettype none

module short_product_high_limbs_unit #(
  parameter int MAX_LIMBS = 16,
  parameter int LIMB_BITS = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // length register write
  input  wire logic                            cfg_write,
  input  wire logic [sphl_pkg::CFG_W-1:0]      cfg_data,
  // operand limb pairs
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [sphl_pkg::PORT_W-1:0]     u_limb,
  input  wire logic [sphl_pkg::PORT_W-1:0]     v_limb,
  // result limbs
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [sphl_pkg::PORT_W-1:0]     result_limb,
  output logic                                 last_limb
);

  // counts run 0..MAX_LIMBS, operand stores are addressed 0..MAX_LIMBS-1,
  // the accumulator window has MAX_LIMBS+1 limbs
  localparam int CNT_W = $clog2(MAX_LIMBS + 1);
  localparam int IDX_W = $clog2(MAX_LIMBS);

  typedef enum logic [2:0] {
    S_LOAD,      // taking operand limb pairs
    S_READ,      // address u, v and the accumulator limb
    S_START,     // read data arrive, kick the multiply-add
    S_MAC,       // wait for the multiply-add, write the window limb
    S_CARRY,     // row done, carry becomes the new top limb
    S_OUT_READ,  // address the next result limb
    S_OUT_CAP,   // capture it into the output register
    S_OUT_WAIT   // hold until the transfer
  } state_t;

  state_t               state;
  logic [sphl_pkg::CFG_W-1:0] limb_count;
  logic [CNT_W-1:0]     loaded_count;
  logic [CNT_W-1:0]     row;
  logic [CNT_W-1:0]     col;
  logic [CNT_W-1:0]     out_idx;
  logic [LIMB_BITS-1:0] carry;
  logic [LIMB_BITS-1:0] out_limb;

  logic [CNT_W-1:0]     n_act;
  logic [CNT_W-1:0]     n_last;
  logic [CNT_W-1:0]     u_pos;

  logic                 in_xfer;
  logic                 out_xfer;

  logic [LIMB_BITS-1:0] u_rdata;
  logic [LIMB_BITS-1:0] v_rdata;
  logic [LIMB_BITS-1:0] acc_rdata;
  logic                 acc_we;
  logic [CNT_W-1:0]     acc_waddr;
  logic [LIMB_BITS-1:0] acc_wdata;
  logic [CNT_W-1:0]     acc_raddr;

  logic                 mac_start;
  logic [LIMB_BITS-1:0] mac_c;
  logic                 mac_done;
  logic [LIMB_BITS-1:0] mac_lo;
  logic [LIMB_BITS-1:0] mac_hi;

  // active length: zero acts as one, anything past the store depth is clipped
  always_comb begin
    if (limb_count == '0) begin
      n_act = CNT_W'(1);
    end else if (32'(limb_count) > 32'(MAX_LIMBS)) begin
      n_act = CNT_W'(MAX_LIMBS);
    end else begin
      n_act = CNT_W'(limb_count);
    end
    n_last = n_act - CNT_W'(1);
    // row i uses the top i+1 limbs of u: u[n-1-i+j]
    u_pos  = n_last - row + col;
  end

  assign in_ready = (state == S_LOAD);
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // operand stores, written on each input transfer
  sphl_ram #(
    .WIDTH (LIMB_BITS),
    .DEPTH (MAX_LIMBS),
    .ADDR_W(IDX_W)
  ) u_store (
    .clk  (clk),
    .we   (in_xfer),
    .waddr(loaded_count[IDX_W-1:0]),
    .wdata(u_limb[LIMB_BITS-1:0]),
    .raddr(u_pos[IDX_W-1:0]),
    .rdata(u_rdata)
  );

  sphl_ram #(
    .WIDTH (LIMB_BITS),
    .DEPTH (MAX_LIMBS),
    .ADDR_W(IDX_W)
  ) v_store (
    .clk  (clk),
    .we   (in_xfer),
    .waddr(loaded_count[IDX_W-1:0]),
    .wdata(v_limb[LIMB_BITS-1:0]),
    .raddr(row[IDX_W-1:0]),
    .rdata(v_rdata)
  );

  // product window: limb j of each row, or the row carry at limb i+1
  always_comb begin
    acc_we    = 1'b0;
    acc_waddr = col;
    acc_wdata = mac_lo;
    if (state == S_MAC && mac_done) begin
      acc_we = 1'b1;
    end else if (state == S_CARRY) begin
      acc_we    = 1'b1;
      acc_waddr = row + CNT_W'(1);
      acc_wdata = carry;
    end
    acc_raddr = (state == S_OUT_READ) ? out_idx : col;
  end

  sphl_ram #(
    .WIDTH (LIMB_BITS),
    .DEPTH (MAX_LIMBS + 1),
    .ADDR_W(CNT_W)
  ) acc_store (
    .clk  (clk),
    .we   (acc_we),
    .waddr(acc_waddr),
    .wdata(acc_wdata),
    .raddr(acc_raddr),
    .rdata(acc_rdata)
  );

  // row 0 starts from an empty window, later rows add into it
  assign mac_start = (state == S_START);
  assign mac_c     = (row == '0) ? '0 : acc_rdata;

  sphl_mac #(
    .LIMB_BITS(LIMB_BITS)
  ) mac (
    .clk  (clk),
    .rst  (rst),
    .start(mac_start),
    .a    (u_rdata),
    .b    (v_rdata),
    .c    (mac_c),
    .d    (carry),
    .done (mac_done),
    .lo   (mac_lo),
    .hi   (mac_hi)
  );

  // sequencer, length register and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      limb_count   <= sphl_pkg::CFG_W'(16);
      loaded_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        // a new length drops any partly loaded operands
        limb_count   <= cfg_data;
        loaded_count <= '0;
      end
      unique case (state)
        S_LOAD: begin
          if (in_xfer) begin
            if (loaded_count + CNT_W'(1) >= n_act) begin
              loaded_count <= '0;
              row          <= '0;
              col          <= '0;
              carry        <= '0;
              state        <= S_READ;
            end else begin
              loaded_count <= loaded_count + CNT_W'(1);
            end
          end
        end
        S_READ: begin
          state <= S_START;
        end
        S_START: begin
          state <= S_MAC;
        end
        S_MAC: begin
          if (mac_done) begin
            carry <= mac_hi;
            if (col == row) begin
              state <= S_CARRY;
            end else begin
              col   <= col + CNT_W'(1);
              state <= S_READ;
            end
          end
        end
        S_CARRY: begin
          if (row == n_last) begin
            out_idx <= '0;
            state   <= S_OUT_READ;
          end else begin
            row   <= row + CNT_W'(1);
            col   <= '0;
            carry <= '0;
            state <= S_READ;
          end
        end
        S_OUT_READ: begin
          state <= S_OUT_CAP;
        end
        S_OUT_CAP: begin
          out_limb  <= acc_rdata;
          last_limb <= (out_idx == n_act);
          out_valid <= 1'b1;
          state     <= S_OUT_WAIT;
        end
        S_OUT_WAIT: begin
          if (out_xfer) begin
            out_valid <= 1'b0;
            if (last_limb) begin
              state <= S_LOAD;
            end else begin
              out_idx <= out_idx + CNT_W'(1);
              state   <= S_OUT_READ;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  assign result_limb = sphl_pkg::PORT_W'(out_limb);

endmodule

`default_nettype wire
